### rtl/core/bpr_pkg.sv
// shared types and constants for the bit-field pixel to rgb565 scaler
package bpr_pkg;

    localparam int WORD_W      = 32;
    localparam int SRC_W       = 11;
    localparam int RND_W       = 9;
    localparam int ERR_W       = 12;
    localparam int COLOR_W     = 16;
    localparam int MAX_COPIES  = 64;
    localparam int COPY_W      = $clog2(MAX_COPIES);
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_RED_MASK     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GREEN_MASK   = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLUE_MASK    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ALPHA_MASK   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH = 3'd4;
    localparam logic [IDX_W-1:0] REG_RENDER_WIDTH = 3'd5;

    // register reset values
    localparam logic [WORD_W-1:0] RED_MASK_RST     = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] GREEN_MASK_RST   = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] BLUE_MASK_RST    = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] ALPHA_MASK_RST   = 32'h0000_0000;
    localparam logic [SRC_W-1:0]  SOURCE_WIDTH_RST = 11'd320;
    localparam logic [RND_W-1:0]  RENDER_WIDTH_RST = 9'd320;

    // top bit that an aligned channel lands on
    localparam logic [2:0] TOP_RB = 3'd4;
    localparam logic [2:0] TOP_G  = 3'd5;

    // one channel mask with its alignment shifts
    typedef struct packed {
        logic [WORD_W-1:0] mask;
        logic [4:0]        shr;
        logic [2:0]        shl;
    } fld_cfg_t;

    typedef struct packed {
        fld_cfg_t red;
        fld_cfg_t green;
        fld_cfg_t blue;
        fld_cfg_t alpha;
    } mask_cfg_t;

    // effective row widths
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [RND_W-1:0] rnd;
    } scl_cfg_t;

endpackage

### rtl/core/bpr_fifo.sv
// small register queue between color front end and copy back end
module bpr_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/bpr_front.sv
// front end: channel extraction, alpha scaling pipeline and rgb565 packing
module bpr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpr_pkg::WORD_W-1:0]    pixel_word,
    input  bpr_pkg::mask_cfg_t            mcfg,
    output logic                          push,
    output logic [bpr_pkg::COLOR_W-1:0]   push_color,
    input  logic                          full
);

    import bpr_pkg::*;

    // masked field aligned to the low channel bits
    function automatic logic [5:0] align_fld(input logic [WORD_W-1:0] word,
                                             input fld_cfg_t f);
        logic [WORD_W-1:0] v;
        v = ((word & f.mask) >> f.shr) << f.shl;
        return v[5:0];
    endfunction

    // three restoring division steps, quotient bits 5:3 or 2:0
    function automatic logic [13:0] div3(input logic [10:0] rem,
                                         input logic [4:0] d,
                                         input logic hi);
        logic [10:0] r;
        logic [10:0] dd;
        logic [2:0]  q;
        r = rem;
        q = '0;
        for (int k = 2; k >= 0; k--)
        begin
            dd = {6'b0, d} << (hi ? k + 3 : k);
            if (r >= dd)
            begin
                r    = r - dd;
                q[k] = 1'b1;
            end
        end
        return {q, r};
    endfunction

    logic en;

    logic        s1_valid_reg;
    logic [4:0]  s1_r_reg, s1_b_reg, s1_mul_reg, s1_div_reg;
    logic [5:0]  s1_g_reg;

    logic        s2_valid_reg;
    logic [10:0] s2_pr_reg, s2_pg_reg, s2_pb_reg;
    logic [4:0]  s2_div_reg;

    logic        s3_valid_reg;
    logic [10:0] s3_rr_reg, s3_rg_reg, s3_rb_reg;
    logic [2:0]  s3_qr_reg, s3_qg_reg, s3_qb_reg;
    logic [4:0]  s3_div_reg;

    logic [4:0]  a_val, a_max, mul_sel, div_sel;
    logic        scale;
    logic [13:0] hr, hg, hb, lr, lg, lb;
    logic [5:0]  qr, qg, qb;

    // whole pipeline holds while the last stage waits on a full queue
    assign en       = !(s3_valid_reg && full);
    assign in_ready = en;
    assign push     = s3_valid_reg && !full;

    // alpha factor: divide by one when no scaling applies
    always_comb
    begin
        a_val = 5'(align_fld(pixel_word, mcfg.alpha));
        a_max = 5'(align_fld(mcfg.alpha.mask, mcfg.alpha));
        scale = (mcfg.alpha.mask != '0) && (a_val != a_max);
        mul_sel = scale ? a_val : 5'd1;
        div_sel = scale ? a_max : 5'd1;
    end

    // high quotient bits
    assign hr = div3(s2_pr_reg, s2_div_reg, 1'b1);
    assign hg = div3(s2_pg_reg, s2_div_reg, 1'b1);
    assign hb = div3(s2_pb_reg, s2_div_reg, 1'b1);

    // low quotient bits and packing
    assign lr = div3(s3_rr_reg, s3_div_reg, 1'b0);
    assign lg = div3(s3_rg_reg, s3_div_reg, 1'b0);
    assign lb = div3(s3_rb_reg, s3_div_reg, 1'b0);
    assign qr = {s3_qr_reg, lr[13:11]};
    assign qg = {s3_qg_reg, lg[13:11]};
    assign qb = {s3_qb_reg, lb[13:11]};
    assign push_color = {qr[4:0], qg, qb[4:0]};

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payload: align, multiply, divide
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg   <= 5'(align_fld(pixel_word, mcfg.red));
            s1_g_reg   <= align_fld(pixel_word, mcfg.green);
            s1_b_reg   <= 5'(align_fld(pixel_word, mcfg.blue));
            s1_mul_reg <= mul_sel;
            s1_div_reg <= div_sel;

            s2_pr_reg  <= {6'b0, s1_r_reg} * {6'b0, s1_mul_reg};
            s2_pg_reg  <= {5'b0, s1_g_reg} * {6'b0, s1_mul_reg};
            s2_pb_reg  <= {6'b0, s1_b_reg} * {6'b0, s1_mul_reg};
            s2_div_reg <= s1_div_reg;

            s3_rr_reg  <= hr[10:0];
            s3_rg_reg  <= hg[10:0];
            s3_rb_reg  <= hb[10:0];
            s3_qr_reg  <= hr[13:11];
            s3_qg_reg  <= hg[13:11];
            s3_qb_reg  <= hb[13:11];
            s3_div_reg <= s2_div_reg;
        end
    end

endmodule

### rtl/core/bpr_back.sv
// back end: error-counter copy expansion and output register
module bpr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  logic [bpr_pkg::COLOR_W-1:0]   head_color,
    output logic                          pop,
    input  bpr_pkg::scl_cfg_t             scl,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpr_pkg::COLOR_W-1:0]   color565,
    output logic                          last_copy
);

    import bpr_pkg::*;

    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [SRC_W-1:0]        cnt_reg, cnt_next;
    logic [COPY_W-1:0]       copy_reg, copy_next;
    logic                    out_valid_reg;
    logic [COLOR_W-1:0]      out_color_reg;
    logic                    out_last_reg;

    logic                    out_free, err_pos, emit, last, fin;
    logic signed [ERR_W:0]   e_ext, w_s, r_s, e_sub, e_fin;
    logic [SRC_W:0]          cnt_inc;

    assign out_free = !out_valid_reg || out_ready;
    assign err_pos  = !err_reg[ERR_W-1] && (err_reg != '0);
    assign emit     = head_valid && err_pos && out_free;
    assign fin      = (emit && last) || (head_valid && !err_pos);
    assign pop      = fin;

    // error arithmetic for one copy step
    always_comb
    begin
        e_ext   = {err_reg[ERR_W-1], err_reg};
        w_s     = $signed({{(ERR_W + 1 - SRC_W){1'b0}}, scl.src});
        r_s     = $signed({{(ERR_W + 1 - RND_W){1'b0}}, scl.rnd});
        e_sub   = e_ext - w_s;
        last    = e_sub[ERR_W] || (e_sub == '0) || (copy_reg == COPY_W'(MAX_COPIES - 1));
        e_fin   = (err_pos ? e_sub : e_ext) + r_s;
        cnt_inc = {1'b0, cnt_reg} + 1'b1;
    end

    // next error, pixel count and copy count
    always_comb
    begin
        err_next  = err_reg;
        cnt_next  = cnt_reg;
        copy_next = copy_reg;
        if (restart)
        begin
            err_next  = '0;
            cnt_next  = '0;
            copy_next = '0;
        end
        else if (fin)
        begin
            copy_next = '0;
            if (cnt_inc >= {1'b0, scl.src})
            begin
                err_next = '0;
                cnt_next = '0;
            end
            else
            begin
                err_next = $signed(e_fin[ERR_W-1:0]);
                cnt_next = cnt_inc[SRC_W-1:0];
            end
        end
        else if (emit)
        begin
            err_next  = $signed(e_sub[ERR_W-1:0]);
            copy_next = copy_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= '0;
            cnt_reg       <= '0;
            copy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            err_reg  <= err_next;
            cnt_reg  <= cnt_next;
            copy_reg <= copy_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_color_reg <= head_color;
            out_last_reg  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign color565  = out_color_reg;
    assign last_copy = out_last_reg;

    // a pixel part way through its copies stays at the queue head
    a_mid_item_head: assert property (@(posedge clk) disable iff (!rst_n)
        (copy_reg != '0) |-> head_valid)
        else $error("copy run in progress without a queued pixel");

    // a copy that is not the last leaves positive error for the next one
    a_more_copies: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last && !restart) |=> err_pos)
        else $error("non-final copy left no error for a further copy");

    // the final copy retires the pixel from the queue
    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |-> pop)
        else $error("final copy did not retire its pixel");

endmodule

### rtl/core/bitfield_pixel_to_rgb565_scaler_top.sv
// top level: configuration registers, front end, queue and copy back end
// Converts one 32-bit bit-field pixel per input transfer into rgb565 and
// repeats or drops it for nearest-neighbour horizontal scaling. The front
// end takes one pixel per cycle, while it is not stalled by a full queue,
// into a three-stage extract, multiply and divide pipeline (alpha scaling
// by alpha/alpha_max); the last stage pushes into the four-entry queue.
// The back end gives each queued pixel 0..64 copies, as set by the row
// error counter; it produces one output transfer per cycle while a pixel
// is queued and the output is free, and the input accepts one pixel per
// cycle while the queue has room. Writing source_width or render_width
// restarts the row. The configuration port is always ready; writes belong
// in idle periods only.
module bitfield_pixel_to_rgb565_scaler_top #(
    parameter int MAX_SOURCE_WIDTH = 1024,
    parameter int MAX_RENDER_WIDTH = 320
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpr_pkg::WORD_W-1:0]    pixel_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpr_pkg::COLOR_W-1:0]   color565,
    output logic                          last_copy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bpr_pkg::WORD_W-1:0]    cfg_data
);

    import bpr_pkg::*;

    localparam int SRC_CAP = (MAX_SOURCE_WIDTH < (1 << SRC_W) - 1) ?
                             MAX_SOURCE_WIDTH : (1 << SRC_W) - 1;
    localparam int RND_CAP = (MAX_RENDER_WIDTH < (1 << RND_W) - 1) ?
                             MAX_RENDER_WIDTH : (1 << RND_W) - 1;
    localparam int MUL_W   = SRC_W + COPY_W;

    // mask with the shifts that bring its top bit onto the channel top
    function automatic fld_cfg_t make_fld(input logic [WORD_W-1:0] mask,
                                          input logic [2:0] top);
        fld_cfg_t   f;
        logic [4:0] msb;
        f.mask = mask;
        msb    = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (mask[i])
            begin
                msb = 5'(i);
            end
        end
        if (msb > {2'b0, top})
        begin
            f.shr = msb - {2'b0, top};
            f.shl = '0;
        end
        else
        begin
            f.shr = '0;
            f.shl = top - msb[2:0];
        end
        return f;
    endfunction

    fld_cfg_t           red_reg, green_reg, blue_reg, alpha_reg;
    logic [SRC_W-1:0]   source_width_reg;
    logic [RND_W-1:0]   render_width_reg;
    scl_cfg_t           scl_reg, scl_next;
    mask_cfg_t          mcfg;

    logic               cfg_wr, restart;
    logic               q_push, q_full, q_pop, q_empty;
    logic [COLOR_W-1:0] q_push_color, q_head_color;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && ((cfg_index == REG_SOURCE_WIDTH) ||
                                  (cfg_index == REG_RENDER_WIDTH));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg          <= make_fld(RED_MASK_RST, TOP_RB);
            green_reg        <= make_fld(GREEN_MASK_RST, TOP_G);
            blue_reg         <= make_fld(BLUE_MASK_RST, TOP_RB);
            alpha_reg        <= make_fld(ALPHA_MASK_RST, TOP_RB);
            source_width_reg <= SOURCE_WIDTH_RST;
            render_width_reg <= RENDER_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_RED_MASK:     red_reg          <= make_fld(cfg_data, TOP_RB);
                REG_GREEN_MASK:   green_reg        <= make_fld(cfg_data, TOP_G);
                REG_BLUE_MASK:    blue_reg         <= make_fld(cfg_data, TOP_RB);
                REG_ALPHA_MASK:   alpha_reg        <= make_fld(cfg_data, TOP_RB);
                REG_SOURCE_WIDTH: source_width_reg <= cfg_data[SRC_W-1:0];
                REG_RENDER_WIDTH: render_width_reg <= cfg_data[RND_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective widths: zero becomes one, saturate, then limit render to 64 times source
    always_comb
    begin
        scl_next.src = source_width_reg;
        if (scl_next.src == '0)
        begin
            scl_next.src = SRC_W'(1);
        end
        if (scl_next.src > SRC_W'(SRC_CAP))
        begin
            scl_next.src = SRC_W'(SRC_CAP);
        end
        scl_next.rnd = render_width_reg;
        if (scl_next.rnd == '0)
        begin
            scl_next.rnd = RND_W'(1);
        end
        if (scl_next.rnd > RND_W'(RND_CAP))
        begin
            scl_next.rnd = RND_W'(RND_CAP);
        end
        if (MUL_W'(scl_next.rnd) > {scl_next.src, {COPY_W{1'b0}}})
        begin
            scl_next.rnd = RND_W'({scl_next.src, {COPY_W{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg <= '0;
        end
        else
        begin
            scl_reg <= scl_next;
        end
    end

    assign mcfg.red   = red_reg;
    assign mcfg.green = green_reg;
    assign mcfg.blue  = blue_reg;
    assign mcfg.alpha = alpha_reg;

    bpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_word (pixel_word),
        .mcfg       (mcfg),
        .push       (q_push),
        .push_color (q_push_color),
        .full       (q_full)
    );

    bpr_fifo #(
        .WIDTH (COLOR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_color),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head_color),
        .empty     (q_empty)
    );

    bpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head_color (q_head_color),
        .pop        (q_pop),
        .scl        (scl_reg),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .color565   (color565),
        .last_copy  (last_copy)
    );

endmodule
